[sv/assert_macros.svh]
// Assertion helpers, clocked on clk with arst_n as the reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/hds_pkg.sv]
package hds_pkg;

	localparam int CHANNELS = 8;
	localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int APB_AW   = 5;

	typedef enum logic [1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_ESTOP  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_MASTER = 3'd0,
		REG_FLOOR  = 3'd1,
		REG_MIN    = 3'd2,
		REG_MAX    = 3'd3,
		REG_STEP   = 3'd4,
		REG_MUTE   = 3'd5
	} reg_idx_t;

	localparam logic [15:0] DEAD_ZONE  = 16'd65;
	localparam logic [15:0] FULL_SCALE = 16'hFFFF;

endpackage

[sv/hds_ifs.sv]
interface hds_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [2:0]         channel;
	logic signed [17:0] pattern_value;
	logic               channel_on;
	logic [15:0]        channel_intensity;

	modport source (
		output valid, kind, channel, pattern_value, channel_on, channel_intensity,
		input  ready
	);
	modport sink (
		input  valid, kind, channel, pattern_value, channel_on, channel_intensity,
		output ready
	);
endinterface

interface hds_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  out_channel;
	logic [15:0] drive;
	logic [15:0] envelope;
	logic        written;
	logic        faulted;

	modport source (
		output valid, out_channel, drive, envelope, written, faulted,
		input  ready
	);
	modport sink (
		input  valid, out_channel, drive, envelope, written, faulted,
		output ready
	);
endinterface

[sv/haptic_drive_shaper_slew_top.sv]
// Channel  Dir  Handshake          Carries
// req      in   valid/ready        kind, channel, pattern_value, channel_on, channel_intensity
// rsp      out  valid/ready        out_channel, drive, envelope, written, faulted
// apb      in   psel/penable       six config registers at 4*i, pready tied high
//
// One item in flight, one step per state in order (MUL1, MUL2, REMAP, FINISH):
// gain multiply, master multiply, remap multiply, then floor/limits/slew with the
// drive memory write. req.ready rises as the result is registered, not before.
// arst_n clears the config to defaults, the fault flag and the drive valid bits
// (drives read as zero until written; estop clears the valid bits at once).
// A waiting result on rsp does not block req; the next one holds in FINISH until drained.
`include "assert_macros.svh"

module haptic_drive_shaper_slew_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [hds_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	hds_in_if.sink                     req,
	hds_out_if.source                  rsp
);
	import hds_pkg::*;

	typedef enum logic [2:0] {IDLE, MUL1, MUL2, REMAP, FINISH} state_t;

	// ---------------- configuration ----------------
	logic [15:0] master_q, floor_q, min_q, max_q, step_q;
	logic        mute_q;
	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_q <= FULL_SCALE;
			floor_q  <= '0;
			min_q    <= '0;
			max_q    <= FULL_SCALE;
			step_q   <= FULL_SCALE;
			mute_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_MASTER: master_q <= pwdata[15:0];
				REG_FLOOR:  floor_q  <= pwdata[15:0];
				REG_MIN:    min_q    <= pwdata[15:0];
				REG_MAX:    max_q    <= pwdata[15:0];
				REG_STEP:   step_q   <= pwdata[15:0];
				REG_MUTE:   mute_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_MASTER: prdata = {16'b0, master_q};
			REG_FLOOR:  prdata = {16'b0, floor_q};
			REG_MIN:    prdata = {16'b0, min_q};
			REG_MAX:    prdata = {16'b0, max_q};
			REG_STEP:   prdata = {16'b0, step_q};
			REG_MUTE:   prdata = {31'b0, mute_q};
			default:    prdata = '0;
		endcase
	end

	// ---------------- control ----------------
	state_t state_q;
	logic   out_valid_q, fault_q;
	logic   acc, fin;

	assign req.ready = (state_q == IDLE);
	assign acc       = req.valid && req.ready;
	// last step completes once the output register is free or being drained
	assign fin       = (state_q == FINISH) && (!out_valid_q || rsp.ready);

	// ---------------- item capture and drive memory ----------------
	logic [1:0]         kind_q;
	logic [2:0]         ch_q;
	logic signed [17:0] pat_q;
	logic               on_q;
	logic [15:0]        ci_q;
	logic [CH_AW-1:0]   addr_q;
	logic               inr_q;

	logic [4:0]         ch_ext;
	logic [CH_AW-1:0]   rd_addr;
	logic               rd_inr;

	assign ch_ext  = {2'b00, req.channel};
	assign rd_addr = ch_ext[CH_AW-1:0];
	assign rd_inr  = (ch_ext < 5'(CHANNELS));

	logic [15:0]         mem_q [CHANNELS];
	logic [15:0]         rd_q;
	logic [CHANNELS-1:0] vld_q;
	logic                mem_we;
	logic [15:0]         mem_wdata;

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= req.kind;
			ch_q   <= req.channel;
			pat_q  <= req.pattern_value;
			on_q   <= req.channel_on;
			ci_q   <= req.channel_intensity;
			addr_q <= rd_addr;
			inr_q  <= rd_inr;
		end
		if (acc && rd_inr)
			rd_q <= mem_q[rd_addr];
		if (fin && mem_we)
			mem_q[addr_q] <= mem_wdata;
	end

	// ---------------- envelope and remap datapath ----------------
	logic [32:0] prod1_q;
	logic [48:0] prod2_q;
	logic [15:0] env_q;
	logic [32:0] remap_q;
	logic        pat_pos;
	logic [15:0] env_sat;

	assign pat_pos = !pat_q[17] && (pat_q != '0);
	assign env_sat = prod2_q[48] ? FULL_SCALE : prod2_q[47:32];

	always_ff @(posedge clk) begin
		if (state_q == MUL1)
			prod1_q <= pat_pos ? 33'(pat_q[16:0]) * 33'(ci_q) : '0;
		if (state_q == MUL2)
			prod2_q <= 49'(prod1_q) * 49'(master_q);
		if (state_q == REMAP) begin
			env_q   <= env_sat;
			remap_q <= 33'(env_sat) * 33'(17'h10000 - 17'(floor_q));
		end
	end

	// ---------------- finish: floor, duty limits, slew ----------------
	logic [16:0]        v_lift;
	logic [16:0]        v_min;
	logic [15:0]        maxd;
	logic [15:0]        v_cap;
	logic [15:0]        prev;
	logic signed [17:0] delta, step_s;
	logic [17:0]        nv;
	logic               drive_on;
	logic               above_dz;

	assign above_dz = (env_q > DEAD_ZONE);
	assign v_lift   = above_dz ? 17'(floor_q) + remap_q[32:16] : 17'(env_q);
	assign v_min    = (above_dz && (min_q != '0) && (v_lift < 17'(min_q))) ? 17'(min_q) : v_lift;
	assign maxd     = (max_q == '0) ? FULL_SCALE : max_q;
	assign v_cap    = (v_min > 17'(maxd)) ? maxd : v_min[15:0];
	assign prev     = vld_q[addr_q] ? rd_q : '0;
	assign delta    = $signed({2'b00, v_cap}) - $signed({2'b00, prev});
	assign step_s   = $signed({2'b00, step_q});
	assign drive_on = on_q && !mute_q;

	always_comb begin
		if (delta > step_s)
			nv = {2'b00, prev} + {2'b00, step_q};
		else if (delta < -step_s)
			nv = {2'b00, prev} - {2'b00, step_q};
		else
			nv = {2'b00, v_cap};
	end

	logic [2:0]  och_n;
	logic [15:0] drive_n, env_n;
	logic        wr_n, fault_n, clr_all;

	always_comb begin
		och_n     = '0;
		drive_n   = '0;
		env_n     = '0;
		wr_n      = 1'b0;
		fault_n   = fault_q;
		clr_all   = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = '0;
		case (kind_t'(kind_q))
			KIND_SAMPLE: begin
				och_n = ch_q;
				if (!fault_q && inr_q) begin
					wr_n   = 1'b1;
					mem_we = 1'b1;
					if (drive_on) begin
						drive_n   = nv[15:0];
						env_n     = env_q;
						mem_wdata = nv[15:0];
					end
				end
			end
			KIND_ESTOP: begin
				fault_n = 1'b1;
				clr_all = 1'b1;
			end
			KIND_CLEAR: fault_n = 1'b0;
			default: ;
		endcase
	end

	// valid bits: an invalid entry reads as zero drive
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (fin && clr_all)
			vld_q <= '0;
		else if (fin && mem_we)
			vld_q[addr_q] <= 1'b1;
	end

	// ---------------- sequencer and output register ----------------
	logic [2:0]  och_q;
	logic [15:0] drive_q, envo_q;
	logic        wr_q, faulto_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
			fault_q     <= 1'b0;
			och_q       <= '0;
			drive_q     <= '0;
			envo_q      <= '0;
			wr_q        <= 1'b0;
			faulto_q    <= 1'b0;
		end else begin
			if (out_valid_q && rsp.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE:   if (acc) state_q <= MUL1;
				MUL1:   state_q <= MUL2;
				MUL2:   state_q <= REMAP;
				REMAP:  state_q <= FINISH;
				FINISH: begin
					if (fin) begin
						state_q     <= IDLE;
						fault_q     <= fault_n;
						out_valid_q <= 1'b1;
						och_q       <= och_n;
						drive_q     <= drive_n;
						envo_q      <= env_n;
						wr_q        <= wr_n;
						faulto_q    <= fault_n;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.out_channel = och_q;
	assign rsp.drive       = drive_q;
	assign rsp.envelope    = envo_q;
	assign rsp.written     = wr_q;
	assign rsp.faulted     = faulto_q;

	// ---------------- checks ----------------
	`ASSERT_CLK(a_start_after_transfer, acc |=> (state_q == MUL1), "item did not start")
	`ASSERT_CLK(a_result_from_finish, $rose(out_valid_q) |-> $past(state_q == FINISH), "stray result")
	`ASSERT_CLK(a_no_write_faulted, out_valid_q |-> !(wr_q && faulto_q), "write while faulted")
	`ASSERT_ALWAYS(a_ready_only_idle, req.ready |-> (state_q == IDLE), "ready while busy")

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

// Random and directed check of the haptic drive shaper: stimulus items are queued,
// fed over the req channel with random idle bursts, predicted at the moment of
// transfer and compared field by field with whatever comes out on rsp.
module testbench;
	import hds_pkg::*;

	// Kind code three has no name in the package; the block must ignore it.
	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 10;   // margin past the item's pass through the block

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         channel;
		logic signed [17:0] pattern_value;
		logic               channel_on;
		logic [15:0]        channel_intensity;
	} sample_item_t;

	typedef struct packed {
		logic [2:0]  chan;
		logic [15:0] drive;
		logic [15:0] env;
		logic        written;
		logic        faulted;
	} drive_result_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [APB_AW-1:0]   paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;

	hds_in_if  req_if ();
	hds_out_if rsp_if ();

	haptic_drive_shaper_slew_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	// Shadow of the block: register file, per-channel drive memory, fault flag.
	logic [15:0] cfg_master, cfg_floor, cfg_min, cfg_max, cfg_step;
	logic        cfg_mute;
	logic [15:0] last_drv [CHANNELS];
	logic        fault_st;

	sample_item_t  sample_queue [$];   // items waiting for the driver
	drive_result_t drive_expect [$];   // predicted results, oldest first
	sample_item_t  held_item;          // item currently presented on req

	int  mismatch_count = 0;
	int  send_gap       = 0;
	int  stall_left     = 0;
	int  quiet_cycles   = 0;
	bit  idle_on        = 1'b1;        // random idling on both sides

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// Predicts one result and updates the shadow state; call once per transfer.
	function automatic drive_result_t shape_drive(sample_item_t it);
		drive_result_t     r;
		logic [63:0]       prod;
		longint unsigned   v, maxd;
		int                prev, nv, delta, stp;
		r = '0;
		case (it.kind)
			KIND_ESTOP: begin
				fault_st = 1'b1;
				foreach (last_drv[i]) last_drv[i] = '0;
			end
			KIND_CLEAR: begin
				fault_st = 1'b0;
			end
			KIND_SAMPLE: begin
				r.chan = it.channel;
				// while faulted a sample writes nothing but echoes its channel
				if (!fault_st) begin
					r.written = 1'b1;
					if (!it.channel_on || cfg_mute) begin
						// off or muted: snap to zero, no slew
						last_drv[it.channel] = '0;
					end else begin
						// exact triple product, then >>32 and saturate; zero or
						// negative patterns give a zero envelope
						prod = '0;
						if (!it.pattern_value[17] && it.pattern_value != 0)
							prod = (64'(it.pattern_value[16:0]) * 64'(it.channel_intensity)
								* 64'(cfg_master)) >> 32;
						r.env = (prod > 64'd65535) ? FULL_SCALE : prod[15:0];
						v = r.env;
						// above the dead zone: lift onto the startup floor,
						// then up to the minimum duty if one is set
						if (r.env > DEAD_ZONE) begin
							v = cfg_floor + ((v * (65536 - cfg_floor)) >> 16);
							if (cfg_min != 0 && v < cfg_min)
								v = cfg_min;
						end
						// a zero cap means full scale
						maxd = (cfg_max == 0) ? FULL_SCALE : cfg_max;
						if (v > maxd)
							v = maxd;
						// slew limit against the channel's last drive
						prev  = last_drv[it.channel];
						stp   = cfg_step;
						nv    = int'(v);
						delta = nv - prev;
						if (delta > stp)
							nv = prev + stp;
						else if (delta < -stp)
							nv = prev - stp;
						last_drv[it.channel] = nv[15:0];
						r.drive = nv[15:0];
					end
				end
			end
			default: ;   // unused code: no effect, fault kept
		endcase
		r.faulted = fault_st;
		return r;
	endfunction

	function automatic sample_item_t mk_item(logic [1:0] kind, int ch, int pat, bit on,
		int unsigned gain);
		sample_item_t it;
		it.kind              = kind;
		it.channel           = ch[2:0];
		it.pattern_value     = pat[17:0];
		it.channel_on        = on;
		it.channel_intensity = gain[15:0];
		return it;
	endfunction

	// Mostly samples with varied content; estop kept rare so the block spends
	// most of its time unfaulted and actually writing drives.
	function automatic sample_item_t rand_item();
		sample_item_t it;
		int unsigned  pick;
		pick = $urandom_range(0, 99);
		if (pick < 2)
			it.kind = KIND_ESTOP;
		else if (pick < 10)
			it.kind = KIND_CLEAR;
		else if (pick < 12)
			it.kind = KIND_UNUSED;
		else
			it.kind = KIND_SAMPLE;
		it.channel    = 3'($urandom_range(0, 7));
		it.channel_on = ($urandom_range(0, 9) != 0);
		case ($urandom_range(0, 3))
			0: it.pattern_value = 18'($urandom());
			1: it.pattern_value = 18'($urandom_range(0, 131071));
			2: it.pattern_value = 18'($urandom_range(0, 200));          // around the dead zone
			default: it.pattern_value = 18'($urandom_range(60000, 70000));  // near unity
		endcase
		case ($urandom_range(0, 3))
			0: it.channel_intensity = 16'hFFFF;
			1: it.channel_intensity = 16'($urandom_range(0, 65535));
			2: it.channel_intensity = 16'($urandom_range(0, 255));
			default: it.channel_intensity = 16'(65535 - $urandom_range(0, 255));
		endcase
		return it;
	endfunction

	// Setup cycle, then access; the register takes the value at the access edge.
	// Upper data bits carry noise, the block keeps only the register's width.
	task automatic apb_write(reg_idx_t idx, int unsigned val);
		logic [31:0] wdata;
		wdata = ($urandom() & 32'hFFFF_0000) | (val & 32'h0000_FFFF);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({idx, 2'b00});
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_MASTER: cfg_master = wdata[15:0];
			REG_FLOOR:  cfg_floor  = wdata[15:0];
			REG_MIN:    cfg_min    = wdata[15:0];
			REG_MAX:    cfg_max    = wdata[15:0];
			REG_STEP:   cfg_step   = wdata[15:0];
			REG_MUTE:   cfg_mute   = wdata[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int unsigned master, int unsigned floor_v,
		int unsigned min_v, int unsigned max_v, int unsigned step, int unsigned mute);
		apb_write(REG_MASTER, master);
		apb_write(REG_FLOOR, floor_v);
		apb_write(REG_MIN, min_v);
		apb_write(REG_MAX, max_v);
		apb_write(REG_STEP, step);
		apb_write(REG_MUTE, mute);
	endtask

	// Checked at the falling edge so the clocked blocks have settled.
	task automatic wait_drained();
		while (sample_queue.size() != 0 || req_if.valid || drive_expect.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic queue_random(int count);
		repeat (count) sample_queue.push_back(rand_item());
	endtask

	// Driver: holds an item until transfer, predicts it at the transfer edge,
	// then loads the next one or goes idle for a burst.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready)
				drive_expect.push_back(shape_drive(held_item));
			if (!req_if.valid || req_if.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					req_if.valid <= 1'b0;
				end else if (sample_queue.size() == 0) begin
					req_if.valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(0, 18);   // idle now, then for send_gap more cycles
					req_if.valid <= 1'b0;
				end else begin
					held_item = sample_queue.pop_front();
					req_if.valid             <= 1'b1;
					req_if.kind              <= held_item.kind;
					req_if.channel           <= held_item.channel;
					req_if.pattern_value     <= held_item.pattern_value;
					req_if.channel_on        <= held_item.channel_on;
					req_if.channel_intensity <= held_item.channel_intensity;
				end
			end
		end
	end

	// Receiver back-pressure in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_if.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 18);
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= 1'b1;
		end
	end

	// Monitor: every result transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		drive_result_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (drive_expect.size() == 0) begin
				report_mismatch("unexpected result, drive", rsp_if.drive, 0);
			end else begin
				want = drive_expect.pop_front();
				if (rsp_if.out_channel !== want.chan)
					report_mismatch("out_channel", rsp_if.out_channel, want.chan);
				if (rsp_if.drive !== want.drive)
					report_mismatch("drive", rsp_if.drive, want.drive);
				if (rsp_if.envelope !== want.env)
					report_mismatch("envelope", rsp_if.envelope, want.env);
				if (rsp_if.written !== want.written)
					report_mismatch("written", rsp_if.written, want.written);
				if (rsp_if.faulted !== want.faulted)
					report_mismatch("faulted", rsp_if.faulted, want.faulted);
			end
		end
	end

	// Watchdog: too long without any transfer on any port ends the run.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		// known values on every input from time zero
		arst_n                   = 1'b0;
		psel                     = 1'b0;
		penable                  = 1'b0;
		pwrite                   = 1'b0;
		paddr                    = '0;
		pwdata                   = '0;
		req_if.valid             = 1'b0;
		req_if.kind              = KIND_SAMPLE;
		req_if.channel           = '0;
		req_if.pattern_value     = '0;
		req_if.channel_on        = 1'b0;
		req_if.channel_intensity = '0;
		rsp_if.ready             = 1'b0;

		// reset values of the register file and drive memory
		cfg_master = FULL_SCALE;
		cfg_floor  = '0;
		cfg_min    = '0;
		cfg_max    = FULL_SCALE;
		cfg_step   = FULL_SCALE;
		cfg_mute   = 1'b0;
		fault_st   = 1'b0;
		foreach (last_drv[i]) last_drv[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at reset settings (no slew limit, no floor).
		sample_queue.push_back(mk_item(KIND_SAMPLE, 0, 131071, 1, 65535));   // saturates
		sample_queue.push_back(mk_item(KIND_SAMPLE, 1, 65536, 1, 65535));    // about unity
		sample_queue.push_back(mk_item(KIND_SAMPLE, 2, -131072, 1, 65535));  // most negative
		sample_queue.push_back(mk_item(KIND_SAMPLE, 3, -1, 1, 65535));
		sample_queue.push_back(mk_item(KIND_SAMPLE, 4, 0, 1, 65535));        // zero pattern
		sample_queue.push_back(mk_item(KIND_SAMPLE, 5, 66, 1, 65535));       // env on dead zone
		sample_queue.push_back(mk_item(KIND_SAMPLE, 5, 67, 1, 65535));       // just above it
		sample_queue.push_back(mk_item(KIND_SAMPLE, 6, 131071, 1, 0));       // zero gain
		sample_queue.push_back(mk_item(KIND_SAMPLE, 7, 65536, 0, 65535));    // channel off
		sample_queue.push_back(mk_item(KIND_SAMPLE, 7, 1, 1, 1));
		sample_queue.push_back(mk_item(KIND_UNUSED, 3, 100, 1, 100));        // ignored kind
		sample_queue.push_back(mk_item(KIND_CLEAR, 0, 0, 0, 0));             // clear, no fault
		sample_queue.push_back(mk_item(KIND_SAMPLE, 4, 40000, 1, 65535));
		sample_queue.push_back(mk_item(KIND_ESTOP, 5, 0, 0, 0));
		sample_queue.push_back(mk_item(KIND_SAMPLE, 0, 65536, 1, 65535));    // while faulted
		sample_queue.push_back(mk_item(KIND_UNUSED, 0, 0, 0, 0));            // fault kept
		sample_queue.push_back(mk_item(KIND_ESTOP, 0, 0, 0, 0));             // estop twice
		sample_queue.push_back(mk_item(KIND_CLEAR, 7, 0, 0, 0));
		sample_queue.push_back(mk_item(KIND_SAMPLE, 4, 32768, 1, 65535));    // restart from zero
		sample_queue.push_back(mk_item(KIND_SAMPLE, 1, -65536, 1, 65535));
		queue_random(110);
		wait_drained();

		// all registers at zero: no gain, zero cap means full scale, zero step holds each drive
		apply_settings(0, 0, 0, 0, 0, 0);
		queue_random(110);
		wait_drained();

		// all registers at their top, muted
		apply_settings(65535, 65535, 65535, 65535, 65535, 1);
		queue_random(110);
		wait_drained();

		// floor, minimum duty, cap and a tight slew together
		apply_settings(65535, 8000, 12000, 50000, 900, 0);
		queue_random(115);
		wait_drained();

		// full floor with a cap of one LSB
		apply_settings(40000, 65535, 0, 1, 65535, 0);
		queue_random(110);
		wait_drained();

		apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), $urandom_range(0, 65535),
			$urandom_range(0, 65535), 0);
		queue_random(115);
		wait_drained();

		// last part: small random slew, both sides flat out
		apply_settings($urandom_range(30000, 65535), $urandom_range(0, 20000),
			$urandom_range(0, 30000), $urandom_range(20000, 65535),
			$urandom_range(1, 4000), 0);
		idle_on = 1'b0;
		queue_random(115);
		wait_drained();

		if (drive_expect.size() != 0)
			report_mismatch("results never delivered", 0, drive_expect.size());
		if (mismatch_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
